/* rtl/racp_pkg.sv */
// ----------------------------------------------------------------------------
// racp_pkg
// Shared types and constants for the rotating arm chain positions core.
// ----------------------------------------------------------------------------
package racp_pkg;

   localparam int PHASE_W   = 24;
   localparam int LEN_W     = 8;
   localparam int RATE_W    = 12;
   localparam int DT_W      = 16;
   localparam int COORD_W   = 22;
   localparam int ROOT_W    = 12;
   localparam int CORD_W    = 34;
   localparam int ITER      = 16;
   localparam int ITER_W    = 4;

   localparam logic [27:0] TURN_SCALE  = 28'd170891319;
   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [COORD_W-1:0] JOINT_MAX = 22'sd2097151;
   localparam logic signed [COORD_W-1:0] JOINT_MIN = -22'sd2097152;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_POSITION = 2'd0,
      ST_ADDED    = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   localparam logic CSR_ROOT_X = 1'b0;
   localparam logic CSR_ROOT_Y = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PROD,
      S_INC,
      S_CORDIC,
      S_MUL,
      S_ACC,
      S_OUT
   } state_type;

   function automatic logic [PHASE_W-1:0] atan_turns(input logic [ITER_W-1:0] i);
      logic [PHASE_W-1:0] v;
      case (i)
         4'd0:  v = 24'd2097152;
         4'd1:  v = 24'd1238021;
         4'd2:  v = 24'd654136;
         4'd3:  v = 24'd332050;
         4'd4:  v = 24'd166669;
         4'd5:  v = 24'd83416;
         4'd6:  v = 24'd41718;
         4'd7:  v = 24'd20860;
         4'd8:  v = 24'd10430;
         4'd9:  v = 24'd5215;
         4'd10: v = 24'd2608;
         4'd11: v = 24'd1304;
         4'd12: v = 24'd652;
         4'd13: v = 24'd326;
         4'd14: v = 24'd163;
         default: v = 24'd81;
      endcase
      return v;
   endfunction

endpackage

/* rtl/rotating_arm_chain_positions_core.sv */
// ----------------------------------------------------------------------------
// rotating_arm_chain_positions_core
// Bounded list of rotating arms; emits the joint chain on every tick.
// ----------------------------------------------------------------------------
// A tick request emits the root point, then walks the arms one at a time:
// each arm reads its entry from the arm store, registers the rate x dt
// product, forms its phase increment with a scale multiply, runs the shared
// 16-step CORDIC (one micro-rotation per cycle), scales cos/sin by the arm
// length and accumulates with saturation; the next arm starts once the
// previous result has been taken. The request side is stalled until all
// results of the current request have been taken. The arm store has no
// reset; of the arm list only the count is cleared.
module rotating_arm_chain_positions_core #(
   parameter int MAX_ARMS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic [racp_pkg::DT_W-1:0]            req_delta_time,
   input  logic [racp_pkg::LEN_W-1:0]           req_arm_length,
   input  logic [racp_pkg::RATE_W-1:0]          req_arm_speed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [4:0]                           rsp_joint_index,
   output logic signed [racp_pkg::COORD_W-1:0]  rsp_joint_x,
   output logic signed [racp_pkg::COORD_W-1:0]  rsp_joint_y,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last,
   input  logic                                 csr_write,
   input  logic                                 csr_index,
   input  logic [racp_pkg::ROOT_W-1:0]          csr_data
);
   import racp_pkg::*;

   localparam int AW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
   localparam int CW = $clog2(MAX_ARMS + 1);

   // arm store: phase, length and rate per entry
   logic [PHASE_W-1:0] phase_mem [MAX_ARMS];
   logic [LEN_W-1:0]   len_mem   [MAX_ARMS];
   logic [RATE_W-1:0]  rate_mem  [MAX_ARMS];

   logic [ROOT_W-1:0] root_x_ff, root_y_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     k_ff, k_in;
   state_type         state_ff, state_in;
   logic [DT_W-1:0]   dt_ff;
   logic [PHASE_W-1:0] ph_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [27:0]        prod_ff;
   logic [55:0]        scaled;
   logic [PHASE_W-1:0] new_phase;
   logic signed [CORD_W+LEN_W:0] mx_ff, my_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [COORD_W+1:0] sx, sy;

   logic [4:0]          o_idx_ff;
   logic signed [COORD_W-1:0] o_x_ff, o_y_ff;
   logic [1:0]          o_st_ff;
   logic                o_last_ff, o_valid_ff;

   logic                cord_start;
   logic                cord_done;
   logic signed [CORD_W-1:0] c_val, s_val;
   logic                fire_in, fire_out;
   logic [AW-1:0]       k_addr;

   assign fire_in  = req_valid && !req_stall;
   assign fire_out = o_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || o_valid_ff;
   assign k_addr   = k_ff[AW-1:0];

   // phase increment: round(rate*dt*scale / 2^32)
   assign scaled    = 56'(prod_ff) * 56'(TURN_SCALE) + 56'h80000000;
   assign new_phase = ph_ff + scaled[PHASE_W+31:32];

   // the rotation starts on the advanced phase
   racp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .phase   (new_phase),
      .done    (cord_done),
      .cos_out (c_val),
      .sin_out (s_val)
   );

   // saturating accumulate of rounded arm offsets
   function automatic logic signed [COORD_W-1:0] sat(input logic signed [COORD_W+1:0] v);
      if (v > (COORD_W+2)'(JOINT_MAX)) return JOINT_MAX;
      if (v < (COORD_W+2)'(JOINT_MIN)) return JOINT_MIN;
      return v[COORD_W-1:0];
   endfunction

   logic signed [CORD_W+LEN_W:0] rx, ry;
   assign rx = (mx_ff + (CORD_W+LEN_W+1)'(1 << 21)) >>> 22;
   assign ry = (my_ff + (CORD_W+LEN_W+1)'(1 << 21)) >>> 22;
   assign sx = (COORD_W+2)'(px_ff) + rx[COORD_W+1:0];
   assign sy = (COORD_W+2)'(py_ff) + ry[COORD_W+1:0];
   assign px_in = sat(sx);
   assign py_in = sat(sy);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (fire_in && req_func == FUNC_TICK && count_ff != '0)
                      state_in = S_OUT;
         S_OUT:    if (!o_valid_ff) state_in = S_READ;
         S_READ:   state_in = S_PROD;
         S_PROD:   state_in = S_INC;
         S_INC:    state_in = S_CORDIC;
         S_CORDIC: if (cord_done) state_in = S_MUL;
         S_MUL:    state_in = S_ACC;
         S_ACC:    state_in = (k_ff + 1'b1 == count_ff) ? S_IDLE : S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cord_start = (state_ff == S_INC);
      count_in = count_ff;
      k_in = k_ff;
      if (fire_in) begin
         k_in = '0;
         if (req_func == FUNC_ADD && count_ff != CW'(MAX_ARMS)) count_in = count_ff + 1'b1;
         if (req_func == FUNC_REMOVE && count_ff != '0) count_in = count_ff - 1'b1;
      end
      if (state_ff == S_ACC) k_in = k_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (fire_in && req_func == FUNC_ADD && count_ff != CW'(MAX_ARMS)) begin
         phase_mem[count_ff[AW-1:0]] <= '0;
         len_mem[count_ff[AW-1:0]]   <= req_arm_length;
         rate_mem[count_ff[AW-1:0]]  <= req_arm_speed;
      end
      if (state_ff == S_READ) begin
         ph_ff   <= phase_mem[k_addr];
         len_ff  <= len_mem[k_addr];
         rate_ff <= rate_mem[k_addr];
      end
      if (state_ff == S_INC) phase_mem[k_addr] <= new_phase;
   end

   always_ff @(posedge clock) begin
      if (fire_in) dt_ff <= req_delta_time;
      prod_ff <= rate_ff * dt_ff;
      if (state_ff == S_MUL) begin
         mx_ff <= $signed({1'b0, len_ff}) * c_val;
         my_ff <= $signed({1'b0, len_ff}) * s_val;
      end
      if (fire_in) begin
         px_ff <= $signed({2'b00, root_x_ff, 8'h00});
         py_ff <= $signed({2'b00, root_y_ff, 8'h00});
      end else if (state_ff == S_ACC) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // control, root and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         k_ff       <= '0;
         root_x_ff  <= 12'd400;
         root_y_ff  <= 12'd300;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         if (csr_write && csr_index == CSR_ROOT_X) root_x_ff <= csr_data;
         if (csr_write && csr_index == CSR_ROOT_Y) root_y_ff <= csr_data;
         if (fire_out) o_valid_ff <= 1'b0;
         if (fire_in) begin
            case (req_func)
               FUNC_TICK:   o_valid_ff <= 1'b1;
               FUNC_ADD:    o_valid_ff <= 1'b1;
               FUNC_REMOVE: o_valid_ff <= (count_ff == '0);
               default:     o_valid_ff <= 1'b0;
            endcase
         end else if (state_ff == S_ACC) begin
            o_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire_in) begin
         case (req_func)
            FUNC_TICK: begin
               o_idx_ff  <= '0;
               o_x_ff    <= $signed({2'b00, root_x_ff, 8'h00});
               o_y_ff    <= $signed({2'b00, root_y_ff, 8'h00});
               o_st_ff   <= ST_POSITION;
               o_last_ff <= (count_ff == '0);
            end
            FUNC_ADD: begin
               o_x_ff    <= '0;
               o_y_ff    <= '0;
               o_last_ff <= 1'b1;
               if (count_ff == CW'(MAX_ARMS)) begin
                  o_idx_ff <= 5'(count_ff);
                  o_st_ff  <= ST_FULL;
               end else begin
                  o_idx_ff <= 5'(count_ff + 1'b1);
                  o_st_ff  <= ST_ADDED;
               end
            end
            default: begin
               o_x_ff    <= '0;
               o_y_ff    <= '0;
               o_last_ff <= 1'b1;
               o_idx_ff  <= '0;
               o_st_ff   <= ST_EMPTY;
            end
         endcase
      end else if (state_ff == S_ACC) begin
         o_idx_ff  <= 5'(k_ff + 1'b1);
         o_x_ff    <= px_in;
         o_y_ff    <= py_in;
         o_st_ff   <= ST_POSITION;
         o_last_ff <= (k_ff + 1'b1 == count_ff);
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_joint_index = o_idx_ff;
   assign rsp_joint_x     = o_x_ff;
   assign rsp_joint_y     = o_y_ff;
   assign rsp_status      = o_st_ff;
   assign rsp_last        = o_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ARMS)) else $error("arm count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_cordic_only_busy: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> state_ff == S_CORDIC) else $error("stray cordic done");

endmodule

/* rtl/racp_cordic.sv */
// ----------------------------------------------------------------------------
// racp_cordic
// Iterative 16-step rotation unit; one micro-rotation per cycle, quadrant
// fold applied on the final result.
// ----------------------------------------------------------------------------
module racp_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [racp_pkg::PHASE_W-1:0]      phase,
   output logic                              done,
   output logic signed [racp_pkg::CORD_W-1:0] cos_out,
   output logic signed [racp_pkg::CORD_W-1:0] sin_out
);
   import racp_pkg::*;

   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [PHASE_W:0]  z_ff, z_in;
   logic [1:0]               q_ff, q_in;
   logic [ITER_W-1:0]        i_ff, i_in;
   logic                     run_ff, run_in, done_ff, done_in;
   logic signed [PHASE_W:0]  at;

   assign at = $signed({1'b0, atan_turns(i_ff)});

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; q_in = q_ff;
      i_in = i_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = $signed({3'b000, phase[PHASE_W-3:0]});
         q_in = phase[PHASE_W-1:PHASE_W-2];
         i_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // arithmetic shift is a floor shift
         if (!z_ff[PHASE_W]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ITER_W'(ITER-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; q_ff <= q_in; i_ff <= i_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;

   always_comb begin
      case (q_ff)
         2'd0: begin cos_out = x_ff;  sin_out = y_ff;  end
         2'd1: begin cos_out = -y_ff; sin_out = x_ff;  end
         2'd2: begin cos_out = -x_ff; sin_out = -y_ff; end
         default: begin cos_out = y_ff; sin_out = -x_ff; end
      endcase
   end

endmodule

/* test/racp_checker.sv */
// ----------------------------------------------------------------------------
// racp_checker
// Watches the request and result channels of the arm chain core, predicts
// every joint from its own copy of the arm list and compares field by field.
// ----------------------------------------------------------------------------
module racp_checker #(
   parameter int MAX_ARMS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic [racp_pkg::DT_W-1:0]            req_delta_time,
   input  logic [racp_pkg::LEN_W-1:0]           req_arm_length,
   input  logic [racp_pkg::RATE_W-1:0]          req_arm_speed,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [4:0]                           rsp_joint_index,
   input  logic signed [racp_pkg::COORD_W-1:0]  rsp_joint_x,
   input  logic signed [racp_pkg::COORD_W-1:0]  rsp_joint_y,
   input  logic [1:0]                           rsp_status,
   input  logic                                 rsp_last,
   input  logic                                 csr_write,
   input  logic                                 csr_index,
   input  logic [racp_pkg::ROOT_W-1:0]          csr_data,
   output int                                   fail_count,
   output int                                   pending_joints,
   output int                                   joint_total
);
   import racp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [4:0]                index;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      status_type                status;
      logic                      last;
   } joint_type;

   joint_type          joint_queue[$];
   logic [ROOT_W-1:0]  root_x_q, root_y_q;
   logic [PHASE_W-1:0] phase_q[MAX_ARMS];
   logic [LEN_W-1:0]   len_q[MAX_ARMS];
   logic [RATE_W-1:0]  rate_q[MAX_ARMS];
   int                 count_q;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   // Quadrant-folded 16-step rotation; returns cos and sin with 30 fraction bits.
   task automatic rotate_phase(input logic [PHASE_W-1:0] ph, output longint c,
                               output longint s);
      longint x, y, z, dx, dy;
      x = CORDIC_GAIN;
      y = 0;
      z = ph[21:0];
      for (int i = 0; i < ITER; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_turns(i[3:0]);
         end else begin
            x += dx; y -= dy; z += atan_turns(i[3:0]);
         end
      end
      case (ph[23:22])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   function automatic longint clamp_coord(longint v);
      if (v > JOINT_MAX) return JOINT_MAX;
      if (v < JOINT_MIN) return JOINT_MIN;
      return v;
   endfunction

   task automatic push_joint(int idx, longint x, longint y, status_type st, bit lst);
      joint_type j;
      j.index = idx[4:0];
      j.x = x[COORD_W-1:0];
      j.y = y[COORD_W-1:0];
      j.status = st;
      j.last = lst;
      joint_queue.push_back(j);
   endtask

   task automatic predict_request();
      longint px, py, c, s;
      longint unsigned p, inc;
      case (func_type'(req_func))
         FUNC_ADD: begin
            if (count_q >= MAX_ARMS) begin
               push_joint(count_q, 0, 0, ST_FULL, 1);
            end else begin
               phase_q[count_q] = '0;
               len_q[count_q] = req_arm_length;
               rate_q[count_q] = req_arm_speed;
               count_q++;
               push_joint(count_q, 0, 0, ST_ADDED, 1);
            end
         end
         FUNC_REMOVE: begin
            if (count_q == 0) push_joint(0, 0, 0, ST_EMPTY, 1);
            else count_q--;
         end
         FUNC_TICK: begin
            px = longint'(root_x_q) * 256;
            py = longint'(root_y_q) * 256;
            push_joint(0, px, py, ST_POSITION, count_q == 0);
            for (int k = 0; k < count_q; k++) begin
               p = longint'(rate_q[k]) * longint'(req_delta_time);
               inc = (p * longint'(TURN_SCALE) + 64'h8000_0000) >> 32;
               phase_q[k] = phase_q[k] + inc[PHASE_W-1:0];
               rotate_phase(phase_q[k], c, s);
               px = clamp_coord(px + floor_shr(longint'(len_q[k]) * c + (64'sd1 << 21), 22));
               py = clamp_coord(py + floor_shr(longint'(len_q[k]) * s + (64'sd1 << 21), 22));
               push_joint(k + 1, px, py, ST_POSITION, k + 1 == count_q);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      joint_type want;
      if (reset) begin
         root_x_q <= 12'd400;
         root_y_q <= 12'd300;
         count_q = 0;
         fail_count <= 0;
         joint_total <= 0;
         joint_queue.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_ROOT_X) root_x_q <= csr_data;
            else root_y_q <= csr_data;
         end
         if (req_valid && !req_stall) predict_request();
         if (rsp_valid && !rsp_stall) begin
            joint_total <= joint_total + 1;
            if (joint_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result idx %0d", $realtime, rsp_joint_index);
               fail_count <= fail_count + 1;
            end else begin
               want = joint_queue.pop_front();
               if (want.index !== rsp_joint_index || want.x !== rsp_joint_x ||
                   want.y !== rsp_joint_y || want.status !== rsp_status ||
                   want.last !== rsp_last) begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch exp idx %0d x %0d y %0d st %0d last %0d",
                              $realtime, want.index, want.x, want.y, want.status,
                              want.last);
                     $display("%0t:          got idx %0d x %0d y %0d st %0d last %0d",
                              $realtime, rsp_joint_index, rsp_joint_x, rsp_joint_y,
                              rsp_status, rsp_last);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_joints = joint_queue.size();
   end
endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the rotating arm chain positions core: directed
// add/remove/tick corner cases, then random arm lists under idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
   import racp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARMS = 16;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_func = '0;
   logic [DT_W-1:0]           req_delta_time = '0;
   logic [LEN_W-1:0]          req_arm_length = '0;
   logic [RATE_W-1:0]         req_arm_speed = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [4:0]                rsp_joint_index;
   logic signed [COORD_W-1:0] rsp_joint_x, rsp_joint_y;
   logic [1:0]                rsp_status;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic                      csr_index = 1'b0;
   logic [ROOT_W-1:0]         csr_data = '0;
   int                        fail_count, pending_joints, joint_total;
   int                        request_total;
   bit                        stall_burst;

   always #5 clock = ~clock;

   rotating_arm_chain_positions_core #(.MAX_ARMS(ARMS)) dut (.*);

   racp_checker #(.MAX_ARMS(ARMS)) checker_inst (.*);

   // Random gap: mostly short, sometimes long.
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Receiver back-pressure; quiet stretches when stall_burst is off.
   always @(posedge clock) begin
      if (!stall_burst) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 :
                        ($urandom_range(0, 3) == 0);
   end

   // Present one request and hold it until accepted, then idle for a random gap, which may be empty.
   task automatic send_request(func_type f, int dt, int len, int spd);
      int gap;
      req_valid <= 1'b1;
      req_func <= f;
      req_delta_time <= dt[DT_W-1:0];
      req_arm_length <= len[LEN_W-1:0];
      req_arm_speed <= spd[RATE_W-1:0];
      do @(posedge clock); while (req_stall);
      request_total++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain all expected results, then let a trailing remove finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_joints != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_root(logic idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[ROOT_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      #50ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int f, n;
      stall_burst = 1'b0;
      request_total = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty remove, lone-root tick, extremes of every field.
      send_request(FUNC_REMOVE, 0, 0, 0);
      send_request(FUNC_TICK, 65535, 0, 0);
      send_request(FUNC_NONE, 65535, 255, 4095);
      send_request(FUNC_ADD, 0, 255, 3072);
      send_request(FUNC_ADD, 0, 0, 0);
      send_request(FUNC_ADD, 0, 170, 1365);
      send_request(FUNC_TICK, 65535, 0, 0);
      send_request(FUNC_TICK, 0, 0, 0);
      send_request(FUNC_TICK, 21845, 0, 0);
      wait_idle();
      write_root(CSR_ROOT_X, 4095);
      write_root(CSR_ROOT_Y, 4095);
      // Fill to the limit, hit full, and tick with the root at its maximum.
      for (int i = 0; i < 14; i++) send_request(FUNC_ADD, 0, 255, 3072 - i * 100);
      send_request(FUNC_ADD, 0, 7, 9);
      send_request(FUNC_TICK, 65535, 0, 0);
      wait_idle();
      write_root(CSR_ROOT_X, 0);
      write_root(CSR_ROOT_Y, 0);
      send_request(FUNC_TICK, 40000, 0, 0);
      send_request(FUNC_REMOVE, 0, 0, 0);
      send_request(FUNC_TICK, 1, 0, 0);

      // Random: adds, removes and ticks on the carried-over arm list, some noise.
      stall_burst = 1'b1;
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         write_root(CSR_ROOT_X, $urandom_range(0, 4095));
         write_root(CSR_ROOT_Y, $urandom_range(0, 4095));
         stall_burst = (phase != 2);
         for (int i = 0; i < 65; i++) begin
            n = $urandom_range(0, 99);
            if (n < 35) f = FUNC_TICK;
            else if (n < 70) f = FUNC_ADD;
            else if (n < 95) f = FUNC_REMOVE;
            else f = FUNC_NONE;
            send_request(func_type'(f[1:0]), $urandom_range(0, 65535),
                         $urandom_range(0, 255),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(3073, 4095)
                                                     : $urandom_range(0, 3072));
         end
      end
      wait_idle();
      repeat (100) @(posedge clock);

      $display("Ran %0d requests, checked %0d results across root extremes, full and empty lists.",
               request_total, joint_total);
      if (fail_count == 0 && pending_joints == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

/* files.f */
rtl/racp_pkg.sv
rtl/racp_cordic.sv
rtl/rotating_arm_chain_positions_core.sv
test/racp_checker.sv
test/tb_top.sv
